FILE: sv/gtl_pkg.sv
// ----------------------------------------------------------------------------
// gtl_pkg
// Types, constants and lookup tables for the Gregorian-to-lunar date converter.
// ----------------------------------------------------------------------------
package gtl_pkg;

  localparam int ROM_ROWS       = 100;
  localparam int TABLE_YEARS_DEF = 100;
  localparam int ROW_W          = $clog2(ROM_ROWS);
  localparam int EPOCH_YEAR     = 1921;
  localparam int EPOCH_OFFSET   = 38;
  localparam int LEAP_WORD_MIN  = 4095;
  localparam int SHORT_MONTH    = 29;
  localparam int CYCLE_LEN      = 60;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int CYCLE_BASE     = (EPOCH_YEAR - 4) % CYCLE_LEN;
  localparam int COUNT_W        = 20;
  localparam int SUM_W          = 22;
  localparam int WORD_W         = 20;

  typedef struct packed {
    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
  } gtl_in_t;

  typedef struct packed {
    logic [10:0] lunar_year;
    logic [3:0]  lunar_month;
    logic        is_leap_month;
    logic [4:0]  lunar_day;
    logic [3:0]  stem_index;
    logic [3:0]  branch_index;
    logic        out_of_range;
  } gtl_out_t;

  typedef struct packed {
    logic               bad;
    logic [COUNT_W-1:0] count;
  } gtl_count_t;

  typedef enum logic [1:0] {
    GTL_IDLE,
    GTL_LOAD,
    GTL_WALK
  } gtl_state_t;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  localparam logic [WORD_W-1:0] YEAR_ROM [ROM_ROWS] = '{
    20'd2635,   20'd333387, 20'd1701,   20'd1748,   20'd267701,
    20'd694,    20'd2391,   20'd133423, 20'd1175,   20'd396438,
    20'd3402,   20'd3749,   20'd331177, 20'd1453,   20'd694,
    20'd201326, 20'd2350,   20'd465197, 20'd3221,   20'd3402,
    20'd400202, 20'd2901,   20'd1386,   20'd267611, 20'd605,
    20'd2349,   20'd137515, 20'd2709,   20'd464533, 20'd1738,
    20'd2901,   20'd330421, 20'd1242,   20'd2651,   20'd199255,
    20'd1323,   20'd529706, 20'd3733,   20'd1706,   20'd398762,
    20'd2741,   20'd1206,   20'd267438, 20'd2647,   20'd1318,
    20'd204070, 20'd3477,   20'd461653, 20'd1386,   20'd2413,
    20'd330077, 20'd1197,   20'd2637,   20'd268877, 20'd3365,
    20'd531109, 20'd2900,   20'd2922,   20'd398042, 20'd2395,
    20'd1179,   20'd267415, 20'd2635,   20'd661067, 20'd1701,
    20'd1748,   20'd398772, 20'd2742,   20'd2391,   20'd330031,
    20'd1175,   20'd1611,   20'd200010, 20'd3749,   20'd527717,
    20'd1452,   20'd2742,   20'd332397, 20'd2350,   20'd3222,
    20'd268949, 20'd3402,   20'd3493,   20'd133973, 20'd1386,
    20'd464219, 20'd605,    20'd2349,   20'd334123, 20'd2709,
    20'd2890,   20'd267946, 20'd2773,   20'd592565, 20'd1210,
    20'd2651,   20'd395863, 20'd1323,   20'd2707,   20'd265877
  };

  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] res;
    res = '0;
    if (month >= 4'd1 && month <= 4'd12) begin
      res = MONTH_START[month - 4'd1];
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] year_word(input logic [ROW_W-1:0] row);
    logic [WORD_W-1:0] res;
    res = '0;
    if (int'(row) < ROM_ROWS) begin
      res = YEAR_ROM[row];
    end
    return res;
  endfunction

  function automatic logic [3:0] year_top(input logic [WORD_W-1:0] word);
    return (word >= WORD_W'(LEAP_WORD_MIN)) ? 4'd12 : 4'd11;
  endfunction

  // returns {stem, branch}
  function automatic logic [7:0] sexagenary(input logic [ROW_W-1:0] row);
    logic [7:0] c;
    logic [7:0] s;
    logic [7:0] b;
    c = 8'(row) + 8'(CYCLE_BASE);
    for (int i = 0; i < 2; i++) begin
      if (c >= 8'(CYCLE_LEN)) c = c - 8'(CYCLE_LEN);
    end
    s = c;
    for (int i = 0; i < 5; i++) begin
      if (s >= 8'd10) s = s - 8'd10;
    end
    b = c;
    for (int i = 0; i < 4; i++) begin
      if (b >= 8'd12) b = b - 8'd12;
    end
    return {s[3:0], b[3:0]};
  endfunction

endpackage

FILE: sv/gtl_day_count.sv
// ----------------------------------------------------------------------------
// gtl_day_count
// Registered day count from the lunar epoch, with the month and range check.
// ----------------------------------------------------------------------------
module gtl_day_count (
  input  logic             clk,
  input  logic             load,
  input  gtl_pkg::gtl_in_t in_item,
  output gtl_pkg::gtl_count_t cnt
);
  import gtl_pkg::*;

  logic [12:0]      dy;
  logic [12:0]      dy_adj;
  logic [12:0]      dy_quarter;
  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] sum;
  logic             leap_add;
  logic             month_bad;
  gtl_count_t       cnt_next;

  always_comb begin
    dy         = 13'({1'b0, in_item.greg_year}) - 13'(EPOCH_YEAR);
    dy_adj     = dy + (dy[12] ? 13'd3 : 13'd0);
    dy_quarter = {dy_adj[12], dy_adj[12], dy_adj[12:2]};
    prod       = SUM_W'(signed'(dy)) * SUM_W'(DAYS_PER_YEAR);
    leap_add   = (in_item.greg_year[1:0] == 2'b00) && (in_item.greg_month > 4'd2);
    month_bad  = (in_item.greg_month == 4'd0) || (in_item.greg_month > 4'd12);
    sum = prod + SUM_W'(signed'(dy_quarter)) + SUM_W'(in_item.greg_day)
        + SUM_W'(month_start(in_item.greg_month)) - SUM_W'(EPOCH_OFFSET)
        + SUM_W'(leap_add);
    cnt_next.bad   = month_bad || sum[SUM_W-1] || (sum == '0);
    cnt_next.count = sum[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= cnt_next;
    end
  end

endmodule

FILE: sv/gtl_month_walk.sv
// ----------------------------------------------------------------------------
// gtl_month_walk
// Month-by-month walk of the lunar year table with one shared compare and
// subtract, and the result register.
// ----------------------------------------------------------------------------
module gtl_month_walk #(
  parameter int TABLE_YEARS = gtl_pkg::TABLE_YEARS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  gtl_pkg::gtl_count_t cnt,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output gtl_pkg::gtl_out_t   out_item
);
  import gtl_pkg::*;

  localparam int ROWS = (TABLE_YEARS < ROM_ROWS) ? TABLE_YEARS : ROM_ROWS;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  gtl_state_t         state, state_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [3:0]         bit_idx, bit_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [WORD_W-1:0]  word;
  logic [3:0]         top;
  logic [4:0]         len;
  logic               fits;
  logic               out_free;
  logic               load_out;
  gtl_out_t           res;
  logic [4:0]         mon;
  logic [4:0]         leap_after;
  logic [7:0]         cyc;

  always_comb begin
    word       = year_word(row);
    top        = year_top(word);
    len        = 5'(SHORT_MONTH) + 5'(word[bit_idx]);
    fits       = count <= COUNT_W'(len);
    out_free   = !out_valid || !out_stall;
    mon        = 5'(top) - 5'(bit_idx) + 5'd1;
    leap_after = {1'b0, word[19:16]};
    cyc        = sexagenary(row);
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    bit_next   = bit_idx;
    count_next = count;
    load_out   = 1'b0;
    res        = '0;
    unique case (state)
      GTL_IDLE: begin
        if (start) state_next = GTL_LOAD;
      end
      GTL_LOAD: begin
        if (cnt.bad) begin
          res.out_of_range = 1'b1;
          if (out_free) begin
            load_out   = 1'b1;
            state_next = GTL_IDLE;
          end
        end else begin
          count_next = cnt.count;
          row_next   = '0;
          bit_next   = year_top(year_word('0));
          state_next = GTL_WALK;
        end
      end
      GTL_WALK: begin
        if (fits) begin
          res.lunar_year  = 11'(EPOCH_YEAR) + 11'(row);
          res.lunar_month = mon[3:0];
          if (top == 4'd12) begin
            if (mon == leap_after + 5'd1) begin
              res.lunar_month   = leap_after[3:0];
              res.is_leap_month = 1'b1;
            end else if (mon > leap_after + 5'd1) begin
              res.lunar_month = mon[3:0] - 4'd1;
            end
          end
          res.lunar_day    = count[4:0];
          res.stem_index   = cyc[7:4];
          res.branch_index = cyc[3:0];
          if (out_free) begin
            load_out   = 1'b1;
            state_next = GTL_IDLE;
          end
        end else if (row == LAST_ROW && bit_idx == 4'd0) begin
          res.out_of_range = 1'b1;
          if (out_free) begin
            load_out   = 1'b1;
            state_next = GTL_IDLE;
          end
        end else begin
          count_next = count - COUNT_W'(len);
          if (bit_idx == 4'd0) begin
            row_next = row + 1'b1;
            bit_next = year_top(year_word(row + 1'b1));
          end else begin
            bit_next = bit_idx - 4'd1;
          end
        end
      end
      default: state_next = GTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    row     <= row_next;
    bit_idx <= bit_next;
    count   <= count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item <= res;
    end
  end

  assign busy = (state != GTL_IDLE);

endmodule

FILE: sv/gregorian_to_lunar_date.sv
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date
// Gregorian date to Chinese lunar date over the table years starting 1921.
// ----------------------------------------------------------------------------
// A conversion registers the day count, then walks the lunar months from the
// lunar new year of 1921 with one compare and subtract per cycle against the
// year table, holding its result while the output register is full and stalled.
// A bad month or a date before 1921-02-08 skips the walk.
// in_stall stays high from the transfer of a date until its result is in the
// output register; a result may wait there while the next date is taken.
// Dates before 1921-02-08, past the table, or with a bad month give a result
// with out_of_range set and every other field zero.
module gregorian_to_lunar_date #(
  parameter int TABLE_YEARS = gtl_pkg::TABLE_YEARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gtl_pkg::gtl_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output gtl_pkg::gtl_out_t out_item
);
  import gtl_pkg::*;

  logic       busy;
  logic       start;
  gtl_count_t cnt;

  assign in_stall = busy;
  assign start    = in_valid && !busy;

  gtl_day_count u_day_count (
    .clk     (clk),
    .load    (start),
    .in_item (in_item),
    .cnt     (cnt)
  );

  gtl_month_walk #(
    .TABLE_YEARS (TABLE_YEARS)
  ) u_month_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cnt       (cnt),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
